// ===== src/gaussian_bspline_approx_unit_macros.svh =====
// Assertion macros shared by the Gaussian spline approximation unit.
`ifndef GAUSSIAN_BSPLINE_APPROX_UNIT_MACROS_SVH
`define GAUSSIAN_BSPLINE_APPROX_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gba: implication check failed");

// Next-cycle implication, disabled during reset.
`define GBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gba: next-cycle check failed");

`endif

// ===== src/gba_pkg.sv =====
`timescale 1ns / 1ps

package gba_pkg;

   // Field widths
   localparam int X_W     = 24;
   localparam int SCALE_W = 24;
   localparam int GAIN_W  = 24;
   localparam int Y_W     = 24;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_GAIN      = 1'b1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd3145728;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd5796330;

   // Squaring and scaling datapath
   localparam int MAG_W    = X_W;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SQ_HALF  = 24;
   localparam int PROD_W   = SQ_HALF + SCALE_W;
   localparam int PHI_KEEP = 33;
   localparam int SUM_W    = PHI_KEEP + SQ_HALF + 1;
   localparam int U_LSB    = 29;
   localparam int U_W      = 28;

   // Exponent table
   localparam int EXP_TABLE_ENTRIES = 256;
   localparam int IDX_W      = $clog2(EXP_TABLE_ENTRIES);
   localparam int ROM_ADDR_W = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int FRAC_W     = U_W;
   localparam int P_W        = U_W + IDX_W;
   localparam int EXP_FRAC   = 30;
   localparam int EXP_W      = EXP_FRAC + 1;
   localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(1) << EXP_FRAC;
   localparam int DF_W       = EXP_W + FRAC_W;
   localparam int YP_W       = GAIN_W + EXP_W;

   typedef logic [EXP_TABLE_ENTRIES:0][EXP_W-1:0] exp_rom_type;

   // Item moving from the scaling stages to the table stages
   typedef struct packed {
      logic           valid;
      logic           flush;
      logic [U_W-1:0] arg;
   } gba_arg_type;

   // Item moving from the table stages to the gain stages
   typedef struct packed {
      logic             valid;
      logic             flush;
      logic [EXP_W-1:0] expo;
   } gba_exp_type;

   // Table build helpers, evaluated at elaboration only
   localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
   localparam logic [63:0] H_STEP  = ((ONE_Q62 / EXP_TABLE_ENTRIES) << 4)
                                   + (((ONE_Q62 % EXP_TABLE_ENTRIES) << 4)
                                      / EXP_TABLE_ENTRIES);

   // round_half_up(a * b / 2^62)
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62] + {63'd0, prod[61]};
   endfunction

   // restoring division by a small count
   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [5:0] den);
      logic [63:0] quo;
      logic [6:0]  rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[5:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-u) samples over 0 <= u <= 16, Q1.30
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      term = ONE_Q62;
      sum  = ONE_Q62;
      e    = ONE_Q62;
      for (int i = 1; i <= 30; i++) begin
         term = div_small(mul_q62(term, H_STEP), 6'(i));
         if (i[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
         rom[k] = EXP_W'((e + (64'd1 << 31)) >> 32);
         e      = mul_q62(e, sum);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

// ===== src/gba_scale.sv =====
`timescale 1ns / 1ps

module gba_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  logic signed [gba_pkg::X_W-1:0]    sample_x,
   input  logic [gba_pkg::SCALE_W-1:0]       exponent_scale,
   output gba_pkg::gba_arg_type              arg_o
);

   localparam int STAGES = 4;

   logic [STAGES-1:0]               valid_ff;
   logic [STAGES-1:0]               valid_in;
   logic [gba_pkg::X_W-1:0]         x_bits;
   logic [gba_pkg::MAG_W-1:0]       mag_in, mag_ff;
   logic [gba_pkg::SQ_W-1:0]        sq_in, sq_ff;
   logic [gba_pkg::PROD_W-1:0]      phi_in, phi_ff;
   logic [gba_pkg::PROD_W-1:0]      plo_in, plo_ff;
   logic [gba_pkg::SUM_W-1:0]       sum;
   logic                            flush_in, flush_ff;
   logic [gba_pkg::U_W-1:0]         arg_in, arg_ff;

   // valid bits shift with the data
   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: magnitude; the most negative code maps to 2^23
   assign x_bits = sample_x;
   assign mag_in = x_bits[gba_pkg::X_W-1] ? (~x_bits + gba_pkg::MAG_W'(1)) : x_bits;

   // stage 2: exact square, Q.32
   assign sq_in = gba_pkg::SQ_W'(mag_ff) * gba_pkg::SQ_W'(mag_ff);

   // stage 3: square times scale as two 24x24 partial products
   assign phi_in = gba_pkg::PROD_W'(sq_ff[gba_pkg::SQ_W-1:gba_pkg::SQ_HALF])
                 * gba_pkg::PROD_W'(exponent_scale);
   assign plo_in = gba_pkg::PROD_W'(sq_ff[gba_pkg::SQ_HALF-1:0])
                 * gba_pkg::PROD_W'(exponent_scale);

   // stage 4: combine, take Q4.24 argument, flag range overflow
   assign sum = gba_pkg::SUM_W'({phi_ff[gba_pkg::PHI_KEEP-1:0],
                                 {gba_pkg::SQ_HALF{1'b0}}})
              + gba_pkg::SUM_W'(plo_ff);
   assign flush_in = (|phi_ff[gba_pkg::PROD_W-1:gba_pkg::PHI_KEEP])
                   | sum[gba_pkg::SUM_W-1];
   assign arg_in = sum[gba_pkg::U_LSB +: gba_pkg::U_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff   <= mag_in;
         sq_ff    <= sq_in;
         phi_ff   <= phi_in;
         plo_ff   <= plo_in;
         flush_ff <= flush_in;
         arg_ff   <= arg_in;
      end
   end

   assign arg_o.valid = valid_ff[STAGES-1];
   assign arg_o.flush = flush_ff;
   assign arg_o.arg   = arg_ff;

endmodule

// ===== src/gba_interp.sv =====
`timescale 1ns / 1ps
`include "gaussian_bspline_approx_unit_macros.svh"

module gba_interp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  gba_pkg::gba_arg_type arg_i,
   output gba_pkg::gba_exp_type exp_o
);

   localparam int STAGES = 3;
   localparam logic [gba_pkg::DF_W:0] DF_HALF = (gba_pkg::DF_W + 1)'(1) << (gba_pkg::FRAC_W - 1);

   logic [STAGES-1:0]                valid_ff;
   logic [STAGES-1:0]                flush_ff;
   logic [gba_pkg::P_W-1:0]          pos;
   logic [gba_pkg::IDX_W-1:0]        idx;
   logic [gba_pkg::ROM_ADDR_W-1:0]   addr0, addr1;
   logic [gba_pkg::EXP_W-1:0]        t0_in, t0_ff, t1_in, t1_ff, t0b_ff;
   logic [gba_pkg::FRAC_W-1:0]       frac_in, frac_ff;
   logic [gba_pkg::EXP_W-1:0]        diff;
   logic [gba_pkg::DF_W-1:0]         df_in, df_ff;
   logic [gba_pkg::DF_W:0]           df_rnd;
   logic [gba_pkg::EXP_W-1:0]        e_in, e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[STAGES-2:0], arg_i.valid};
      end
   end

   // stage 5: table position, neighbor samples
   assign pos     = gba_pkg::P_W'(arg_i.arg) * gba_pkg::P_W'(gba_pkg::EXP_TABLE_ENTRIES);
   assign idx     = pos[gba_pkg::P_W-1:gba_pkg::FRAC_W];
   assign frac_in = pos[gba_pkg::FRAC_W-1:0];
   assign addr0   = gba_pkg::ROM_ADDR_W'(idx);
   assign addr1   = addr0 + gba_pkg::ROM_ADDR_W'(1);
   assign t0_in   = gba_pkg::EXP_ROM[addr0];
   assign t1_in   = gba_pkg::EXP_ROM[addr1];

   // stage 6: slope times fraction
   assign diff  = (t0_ff >= t1_ff) ? (t0_ff - t1_ff) : '0;
   assign df_in = gba_pkg::DF_W'(diff) * gba_pkg::DF_W'(frac_ff);

   // stage 7: rounded correction off the left sample
   assign df_rnd = {1'b0, df_ff} + DF_HALF;
   assign e_in   = t0b_ff - df_rnd[gba_pkg::FRAC_W +: gba_pkg::EXP_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         flush_ff <= {flush_ff[STAGES-2:0], arg_i.flush};
         t0_ff    <= t0_in;
         t1_ff    <= t1_in;
         frac_ff  <= frac_in;
         t0b_ff   <= t0_ff;
         df_ff    <= df_in;
         e_ff     <= e_in;
      end
   end

   assign exp_o.valid = valid_ff[STAGES-1];
   assign exp_o.flush = flush_ff[STAGES-1];
   assign exp_o.expo  = e_ff;

   `GBA_ASSERT_IMPLY(a_exp_in_range, clock, reset, exp_o.valid && !exp_o.flush, exp_o.expo <= gba_pkg::EXP_ONE)

endmodule

// ===== src/gba_gain.sv =====
`timescale 1ns / 1ps
`include "gaussian_bspline_approx_unit_macros.svh"

module gba_gain (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  gba_pkg::gba_exp_type        exp_i,
   input  logic [gba_pkg::GAIN_W-1:0]  peak_gain,
   output logic                        out_valid,
   output logic [gba_pkg::Y_W-1:0]     spline_value
);

   localparam logic [gba_pkg::YP_W:0] YP_HALF = (gba_pkg::YP_W + 1)'(1) << (gba_pkg::EXP_FRAC - 1);

   logic [1:0]                 valid_ff;
   logic                       flush_ff;
   logic [gba_pkg::YP_W-1:0]   yp_in, yp_ff;
   logic [gba_pkg::YP_W:0]     yp_rnd;
   logic [gba_pkg::Y_W-1:0]    y_in, y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[0], exp_i.valid};
      end
   end

   // stage 8: gain times exponent
   assign yp_in = gba_pkg::YP_W'(peak_gain) * gba_pkg::YP_W'(exp_i.expo);

   // stage 9: round to Q1.23, zero on underflow
   assign yp_rnd = {1'b0, yp_ff} + YP_HALF;
   assign y_in   = flush_ff ? '0 : yp_rnd[gba_pkg::EXP_FRAC +: gba_pkg::Y_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         flush_ff <= exp_i.flush;
         yp_ff    <= yp_in;
         y_ff     <= y_in;
      end
   end

   assign out_valid    = valid_ff[1];
   assign spline_value = y_ff;

   `GBA_ASSERT_IMPLY(a_value_le_gain, clock, reset, out_valid, spline_value <= peak_gain)
   `GBA_ASSERT_NEXT(a_flush_gives_zero, clock, reset, enable && exp_i.valid && exp_i.flush, !enable || flush_ff)

endmodule

// ===== src/gaussian_bspline_approx_unit.sv =====
`timescale 1ns / 1ps
`include "gaussian_bspline_approx_unit_macros.svh"
// Gaussian approximation to an order-n B-spline: y = gain * exp(-x*x * scale).
// Channels:
//   req_*  one signed Q8.16 sample word per valid/ready handshake.
//   rsp_*  one unsigned Q1.23 spline word per handshake, in input order.
//   csr_*  register writes: index 0 exponent_scale (Q3.21), 1 peak_gain (Q1.23).
//          csr_ready is always high; write only while the pipe is empty.
// Throughput: one word per cycle unless the output stalls, set by the single-issue nine-stage pipe
//   (abs, square, scale products, sum/flush, table read, slope multiply,
//   interpolate, gain multiply, round).
// Arguments of 16.0 or more give a result of 0.
// Stall: while rsp_valid is high and rsp_ready low, every stage holds and
//   req_ready is low; no word is dropped or repeated.
// Reset (synchronous, active high): empties the pipe and returns both
//   registers to their defaults (scale 1.5, gain for a cubic spline).
module gaussian_bspline_approx_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gba_pkg::X_W-1:0]       req_sample_x,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gba_pkg::Y_W-1:0]              rsp_spline_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gba_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gba_pkg::SCALE_W-1:0]          csr_data
);

   logic                          enable;
   logic [gba_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic [gba_pkg::GAIN_W-1:0]    gain_ff, gain_in;
   gba_pkg::gba_arg_type          arg_bus;
   gba_pkg::gba_exp_type          exp_bus;

   // whole pipe advances unless the output word is held
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      scale_in = scale_ff;
      gain_in  = gain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gba_pkg::CSR_EXPONENT_SCALE: scale_in = csr_data;
            gba_pkg::CSR_PEAK_GAIN:      gain_in  = gba_pkg::GAIN_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= gba_pkg::SCALE_RESET;
         gain_ff  <= gba_pkg::GAIN_RESET;
      end else begin
         scale_ff <= scale_in;
         gain_ff  <= gain_in;
      end
   end

   gba_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_valid       (req_valid),
      .sample_x       (req_sample_x),
      .exponent_scale (scale_ff),
      .arg_o          (arg_bus)
   );

   gba_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .arg_i  (arg_bus),
      .exp_o  (exp_bus)
   );

   gba_gain u_gain (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .exp_i        (exp_bus),
      .peak_gain    (gain_ff),
      .out_valid    (rsp_valid),
      .spline_value (rsp_spline_value)
   );

   `GBA_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule
